>>> src/tmwn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmwn_pkg
// Types, widths, sequencer program and arctangent table for the mesh winding
// number block.
// ----------------------------------------------------------------------------
package tmwn_pkg;

   localparam int V_W     = 16;  // normalized vector component, signed
   localparam int MA_W    = 34;  // multiplier operand a, signed
   localparam int MB_W    = 24;  // multiplier operand b, signed
   localparam int P_W     = 58;  // product, signed
   localparam int ACC_W   = 56;  // accumulator, det, divisor, cordic x/y
   localparam int SS_W    = 32;  // sum of squares
   localparam int NRM_W   = 22;  // vector norm, 6 fraction bits
   localparam int SQ_IN_W = 44;  // square root operand
   localparam int REM_W   = 24;  // square root remainder
   localparam int P1_W    = 38;  // first norm product
   localparam int SPLIT   = 19;  // split point of the first norm product
   localparam int ZW      = 36;  // angle in 2^-32 turn
   localparam int SUM_W   = 32;

   localparam logic [1:0] CSR_QUERY_X = 2'd0;
   localparam logic [1:0] CSR_QUERY_Y = 2'd1;
   localparam logic [1:0] CSR_QUERY_Z = 2'd2;

   localparam logic [5:0] MAC_STEP_SQRT = 6'd26;
   localparam logic [5:0] MAC_STEP_LAST = 6'd32;

   localparam logic signed [ACC_W-1:0] LIM_COARSE = 56'sh0000_2000_0000_0000;
   localparam logic signed [ACC_W-1:0] LIM_FINE   = 56'sh0002_0000_0000_0000;
   localparam logic signed [ZW-1:0]    HALF_TURN  = 36'sh0_8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_MUL,
      ST_ACC,
      ST_SQRT,
      ST_ATAN_PREP,
      ST_ATAN_NORM,
      ST_CORDIC,
      ST_ACCUM
   } state_type;

   typedef enum logic [2:0] {A_V, A_CR, A_DOT, A_NRM, A_P1HI, A_P1LO} opa_type;
   typedef enum logic {B_V, B_NRM} opb_type;
   typedef enum logic [1:0] {SH_NONE, SH_R6, SH_R12, SH_L7} shift_type;
   typedef enum logic [2:0] {D_NONE, D_CR, D_DET, D_SS, D_DOT, D_P1, D_DIV} dst_type;

   typedef struct packed {
      opa_type    asel;
      logic [3:0] aidx;
      opb_type    bsel;
      logic [3:0] bidx;
      logic       clear;
      logic       neg;
      shift_type  shift;
      dst_type    dst;
      logic [1:0] didx;
   } mac_op_type;

   function automatic mac_op_type mk(input opa_type asel, input logic [3:0] aidx,
                                     input opb_type bsel, input logic [3:0] bidx,
                                     input logic clear, input logic neg,
                                     input shift_type shift, input dst_type dst,
                                     input logic [1:0] didx);
      mac_op_type r;
      r.asel  = asel;
      r.aidx  = aidx;
      r.bsel  = bsel;
      r.bidx  = bidx;
      r.clear = clear;
      r.neg   = neg;
      r.shift = shift;
      r.dst   = dst;
      r.didx  = didx;
      return r;
   endfunction

   // vector order: a.x a.y a.z b.x b.y b.z c.x c.y c.z
   function automatic mac_op_type mac_op(input logic [5:0] step);
      mac_op_type r;
      unique case (step)
         6'd0:  r = mk(A_V, 4'd4, B_V, 4'd8, 1'b1, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd1:  r = mk(A_V, 4'd5, B_V, 4'd7, 1'b0, 1'b1, SH_NONE, D_CR, 2'd0);
         6'd2:  r = mk(A_V, 4'd5, B_V, 4'd6, 1'b1, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd3:  r = mk(A_V, 4'd3, B_V, 4'd8, 1'b0, 1'b1, SH_NONE, D_CR, 2'd1);
         6'd4:  r = mk(A_V, 4'd3, B_V, 4'd7, 1'b1, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd5:  r = mk(A_V, 4'd4, B_V, 4'd6, 1'b0, 1'b1, SH_NONE, D_CR, 2'd2);
         6'd6:  r = mk(A_CR, 4'd0, B_V, 4'd0, 1'b1, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd7:  r = mk(A_CR, 4'd1, B_V, 4'd1, 1'b0, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd8:  r = mk(A_CR, 4'd2, B_V, 4'd2, 1'b0, 1'b0, SH_NONE, D_DET, 2'd0);
         6'd9:  r = mk(A_V, 4'd0, B_V, 4'd0, 1'b1, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd10: r = mk(A_V, 4'd1, B_V, 4'd1, 1'b0, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd11: r = mk(A_V, 4'd2, B_V, 4'd2, 1'b0, 1'b0, SH_NONE, D_SS, 2'd0);
         6'd12: r = mk(A_V, 4'd3, B_V, 4'd3, 1'b1, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd13: r = mk(A_V, 4'd4, B_V, 4'd4, 1'b0, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd14: r = mk(A_V, 4'd5, B_V, 4'd5, 1'b0, 1'b0, SH_NONE, D_SS, 2'd1);
         6'd15: r = mk(A_V, 4'd6, B_V, 4'd6, 1'b1, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd16: r = mk(A_V, 4'd7, B_V, 4'd7, 1'b0, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd17: r = mk(A_V, 4'd8, B_V, 4'd8, 1'b0, 1'b0, SH_NONE, D_SS, 2'd2);
         6'd18: r = mk(A_V, 4'd0, B_V, 4'd3, 1'b1, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd19: r = mk(A_V, 4'd1, B_V, 4'd4, 1'b0, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd20: r = mk(A_V, 4'd2, B_V, 4'd5, 1'b0, 1'b0, SH_NONE, D_DOT, 2'd0);
         6'd21: r = mk(A_V, 4'd3, B_V, 4'd6, 1'b1, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd22: r = mk(A_V, 4'd4, B_V, 4'd7, 1'b0, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd23: r = mk(A_V, 4'd5, B_V, 4'd8, 1'b0, 1'b0, SH_NONE, D_DOT, 2'd1);
         6'd24: r = mk(A_V, 4'd6, B_V, 4'd0, 1'b1, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd25: r = mk(A_V, 4'd7, B_V, 4'd1, 1'b0, 1'b0, SH_NONE, D_NONE, 2'd0);
         6'd26: r = mk(A_V, 4'd8, B_V, 4'd2, 1'b0, 1'b0, SH_NONE, D_DOT, 2'd2);
         6'd27: r = mk(A_NRM, 4'd0, B_NRM, 4'd1, 1'b1, 1'b0, SH_R6, D_P1, 2'd0);
         6'd28: r = mk(A_P1HI, 4'd0, B_NRM, 4'd2, 1'b1, 1'b0, SH_L7, D_NONE, 2'd0);
         6'd29: r = mk(A_P1LO, 4'd0, B_NRM, 4'd2, 1'b0, 1'b0, SH_R12, D_NONE, 2'd0);
         6'd30: r = mk(A_DOT, 4'd0, B_NRM, 4'd2, 1'b0, 1'b0, SH_R6, D_NONE, 2'd0);
         6'd31: r = mk(A_DOT, 4'd1, B_NRM, 4'd0, 1'b0, 1'b0, SH_R6, D_NONE, 2'd0);
         6'd32: r = mk(A_DOT, 4'd2, B_NRM, 4'd1, 1'b0, 1'b0, SH_R6, D_DIV, 2'd0);
         default: r = mk(A_V, 4'd0, B_V, 4'd0, 1'b1, 1'b0, SH_NONE, D_NONE, 2'd0);
      endcase
      return r;
   endfunction

   // atan(2^-k) in 2^-32 turn
   function automatic logic [31:0] turn_atan(input logic [4:0] k);
      logic [31:0] r;
      unique case (k)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         5'd31: r = 32'h00000000;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

>>> src/tmwn_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmwn_req_if
// Triangle channel: three vertices and the last-triangle mark.
// ----------------------------------------------------------------------------
interface tmwn_req_if #(
   parameter int COORD_BITS = 24
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vert_a_x;
   logic signed [COORD_BITS-1:0] vert_a_y;
   logic signed [COORD_BITS-1:0] vert_a_z;
   logic signed [COORD_BITS-1:0] vert_b_x;
   logic signed [COORD_BITS-1:0] vert_b_y;
   logic signed [COORD_BITS-1:0] vert_b_z;
   logic signed [COORD_BITS-1:0] vert_c_x;
   logic signed [COORD_BITS-1:0] vert_c_y;
   logic signed [COORD_BITS-1:0] vert_c_z;
   logic                         last_triangle;

   modport source (
      output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
             vert_c_x, vert_c_y, vert_c_z, last_triangle,
      input  ready
   );

   modport sink (
      input  valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
             vert_c_x, vert_c_y, vert_c_z, last_triangle,
      output ready
   );
endinterface

>>> src/tmwn_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmwn_rsp_if
// Result channel: winding sum, triangle count and overflow flag.
// ----------------------------------------------------------------------------
interface tmwn_rsp_if #(
   parameter int COUNT_BITS = 20
);
   logic                   valid;
   logic                   ready;
   logic signed [31:0]     winding_sum;
   logic [COUNT_BITS-1:0]  triangle_total;
   logic                   sum_overflow;

   modport source (
      output valid, winding_sum, triangle_total, sum_overflow,
      input  ready
   );

   modport sink (
      input  valid, winding_sum, triangle_total, sum_overflow,
      output ready
   );
endinterface

>>> src/triangle_mesh_winding_number.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_mesh_winding_number
// Generalized winding number of a triangle mesh about a query point, built
// around one shared multiply-accumulate unit, a bit-serial square root and a
// CORDIC vectoring loop under a small sequencer.
// ----------------------------------------------------------------------------
// order: vector scaling, 33 multiply steps (a multiply state, then an accumulate
//   state) on the one multiplier with three bit-serial square roots after step 26,
//   angle scaling, CORDIC_STEPS CORDIC iterations and the accumulate step;
//   one word in flight at a time
// a finished result waits in an output register
// reset (synchronous): clears query point, accumulator, count, flag, result valid
module triangle_mesh_winding_number
   import tmwn_pkg::*;
#(
   parameter int COORD_BITS   = 24,
   parameter int CORDIC_STEPS = 24,
   parameter int COUNT_BITS   = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   tmwn_req_if.sink              req_if,
   tmwn_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata
);

   localparam int MAG_W = (COORD_BITS + 1 > V_W) ? COORD_BITS + 1 : V_W;
   localparam int CIW   = $clog2(CORDIC_STEPS);

   state_type state_ff, state_in;

   logic signed [COORD_BITS-1:0] qx_ff, qy_ff, qz_ff;

   logic signed [COORD_BITS-1:0] vin [9];
   logic signed [COORD_BITS-1:0] qsel [9];
   logic [MAG_W-1:0]             mag_new [9];
   logic [8:0]                   neg_new;

   logic [MAG_W-1:0]        mag_ff [9];
   logic [8:0]              neg_ff;
   logic                    last_ff;
   logic [MAG_W-1:0]        mag_or;
   logic [63:0]             mag_or64;
   logic signed [V_W-1:0]   v [9];

   logic [5:0]              step_ff;
   mac_op_type              op;
   logic signed [MA_W-1:0]  opa;
   logic signed [MB_W-1:0]  opb;
   logic signed [P_W-1:0]   prod_in, prod_ff;
   logic signed [ACC_W-1:0] term, acc_in, acc_ff;

   logic signed [MA_W-1:0]  cr_ff [3];
   logic signed [MA_W-1:0]  dot_ff [3];
   logic [SS_W-1:0]         ss_ff [3];
   logic [NRM_W-1:0]        nrm_ff [3];
   logic [P1_W-1:0]         p1_ff;
   logic signed [ACC_W-1:0] det_ff, div_ff;

   logic [1:0]              sq_sel_ff;
   logic [4:0]              sq_cnt_ff;
   logic [SQ_IN_W-1:0]      sq_src_ff;
   logic [REM_W-1:0]        sq_rem_ff, sq_rem_in;
   logic [NRM_W-1:0]        sq_root_ff, sq_root_in;
   logic [REM_W+1:0]        sq_rem_sh, sq_trial;
   logic                    sq_ge;
   logic                    sq_done;
   logic [SS_W-1:0]         sq_next_ss;

   logic signed [ACC_W-1:0] x_ff, y_ff;
   logic signed [ZW-1:0]    z_ff;
   logic [CIW-1:0]          cordic_ff;
   logic signed [ACC_W-1:0] dx, dy;
   logic signed [ZW-1:0]    tab;
   logic                    coarse_ok, fine_ok;

   logic signed [ZW-1:0]    z_round;
   logic signed [ZW-9:0]    contrib;
   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] wacc_ff, wacc_in;
   logic                    ovf_ff, ovf_in;
   logic [COUNT_BITS-1:0]   cnt_ff, cnt_in;

   logic                    rsp_valid_ff;
   logic signed [SUM_W-1:0] rsp_sum_ff;
   logic [COUNT_BITS-1:0]   rsp_cnt_ff;
   logic                    rsp_ovf_ff;
   logic                    out_free;
   logic                    req_rdy;
   logic                    rsp_load;

   // ---------------------------------------------------------------- inputs
   assign vin[0] = req_if.vert_a_x;
   assign vin[1] = req_if.vert_a_y;
   assign vin[2] = req_if.vert_a_z;
   assign vin[3] = req_if.vert_b_x;
   assign vin[4] = req_if.vert_b_y;
   assign vin[5] = req_if.vert_b_z;
   assign vin[6] = req_if.vert_c_x;
   assign vin[7] = req_if.vert_c_y;
   assign vin[8] = req_if.vert_c_z;

   for (genvar i = 0; i < 9; i++) begin : g_diff
      logic signed [COORD_BITS:0] dif;
      logic [COORD_BITS:0]        dabs;
      if (i % 3 == 0) begin : g_x
         assign qsel[i] = qx_ff;
      end else if (i % 3 == 1) begin : g_y
         assign qsel[i] = qy_ff;
      end else begin : g_z
         assign qsel[i] = qz_ff;
      end
      assign dif        = (COORD_BITS+1)'(vin[i]) - (COORD_BITS+1)'(qsel[i]);
      assign dabs       = dif[COORD_BITS] ? (COORD_BITS+1)'(-dif) : (COORD_BITS+1)'(dif);
      assign mag_new[i] = MAG_W'(dabs);
      assign neg_new[i] = dif[COORD_BITS];
      assign v[i] = neg_ff[i] ? -signed'(mag_ff[i][V_W-1:0]) : signed'(mag_ff[i][V_W-1:0]);
   end

   always_comb begin
      mag_or = '0;
      for (int i = 0; i < 9; i++) begin
         mag_or = mag_or | mag_ff[i];
      end
   end
   assign mag_or64 = 64'(mag_or);

   // ---------------------------------------------------------------- mac unit
   always_comb begin
      op = mac_op(step_ff);
      case (op.asel)
         A_V:     opa = MA_W'(v[op.aidx]);
         A_CR:    opa = cr_ff[op.aidx[1:0]];
         A_DOT:   opa = dot_ff[op.aidx[1:0]];
         A_NRM:   opa = signed'(MA_W'(nrm_ff[op.aidx[1:0]]));
         A_P1HI:  opa = signed'(MA_W'(p1_ff[P1_W-1:SPLIT]));
         A_P1LO:  opa = signed'(MA_W'(p1_ff[SPLIT-1:0]));
         default: opa = '0;
      endcase
      case (op.bsel)
         B_V:     opb = MB_W'(v[op.bidx]);
         B_NRM:   opb = signed'(MB_W'(nrm_ff[op.bidx[1:0]]));
         default: opb = '0;
      endcase
   end

   assign prod_in = opa * opb;

   always_comb begin
      case (op.shift)
         SH_NONE: term = ACC_W'(prod_ff);
         SH_R6:   term = ACC_W'(prod_ff >>> 6);
         SH_R12:  term = ACC_W'(prod_ff >>> 12);
         SH_L7:   term = ACC_W'(prod_ff <<< 7);
         default: term = '0;
      endcase
      acc_in = (op.clear ? '0 : acc_ff) + (op.neg ? -term : term);
   end

   // ---------------------------------------------------------------- square root
   always_comb begin
      sq_rem_sh  = {sq_rem_ff, sq_src_ff[SQ_IN_W-1 -: 2]};
      sq_trial   = (REM_W+2)'({sq_root_ff, 2'b01});
      sq_ge      = sq_rem_sh >= sq_trial;
      sq_rem_in  = sq_ge ? REM_W'(sq_rem_sh - sq_trial) : REM_W'(sq_rem_sh);
      sq_root_in = {sq_root_ff[NRM_W-2:0], sq_ge};
      sq_done    = sq_cnt_ff == 5'(NRM_W - 1);
      case (sq_sel_ff)
         2'd0:    sq_next_ss = ss_ff[1];
         default: sq_next_ss = ss_ff[2];
      endcase
   end

   // ---------------------------------------------------------------- angle
   assign coarse_ok = (x_ff < LIM_COARSE) && (x_ff > -LIM_COARSE) &&
                      (y_ff < LIM_COARSE) && (y_ff > -LIM_COARSE);
   assign fine_ok   = (x_ff < LIM_FINE) && (x_ff > -LIM_FINE) &&
                      (y_ff < LIM_FINE) && (y_ff > -LIM_FINE);
   assign dx        = y_ff >>> cordic_ff;
   assign dy        = x_ff >>> cordic_ff;
   assign tab       = signed'(ZW'(turn_atan(5'(cordic_ff))));

   // ---------------------------------------------------------------- accumulate
   assign z_round  = z_ff + ZW'(128);
   assign contrib  = z_round[ZW-1:8];
   assign sum_wide = (SUM_W+1)'(wacc_ff) + (SUM_W+1)'(contrib);

   always_comb begin
      wacc_in = SUM_W'(sum_wide);
      ovf_in  = ovf_ff;
      if (sum_wide > (SUM_W+1)'(33'sh0_7FFF_FFFF)) begin
         wacc_in = 32'sh7FFF_FFFF;
         ovf_in  = 1'b1;
      end else if (sum_wide < (SUM_W+1)'(-33'sh0_8000_0000)) begin
         wacc_in = -32'sh8000_0000;
         ovf_in  = 1'b1;
      end
      cnt_in = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) state_in = ST_NORM;
         end
         ST_NORM: begin
            if (mag_or64 == 64'd0) begin
               state_in = ST_ACCUM;
            end else if (mag_or64 < 64'd32768 && mag_or64 >= 64'd16384) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (step_ff == MAC_STEP_SQRT) begin
               state_in = ST_SQRT;
            end else if (step_ff == MAC_STEP_LAST) begin
               state_in = ST_ATAN_PREP;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_SQRT: begin
            if (sq_done && sq_sel_ff == 2'd2) state_in = ST_MUL;
         end
         ST_ATAN_PREP: begin
            if (div_ff == '0 && det_ff == '0) begin
               state_in = ST_ACCUM;
            end else begin
               state_in = ST_ATAN_NORM;
            end
         end
         ST_ATAN_NORM: begin
            if (!fine_ok) state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (cordic_ff == CIW'(CORDIC_STEPS - 1)) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (!last_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_rdy  = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_rdy  = 1'b1;
         ST_ACCUM: rsp_load = last_ff && out_free;
         default: begin
            req_rdy  = 1'b0;
            rsp_load = 1'b0;
         end
      endcase
   end

   assign req_if.ready          = req_rdy;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.winding_sum    = rsp_sum_ff;
   assign rsp_if.triangle_total = rsp_cnt_ff;
   assign rsp_if.sum_overflow   = rsp_ovf_ff;

   // ---------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         qx_ff        <= '0;
         qy_ff        <= '0;
         qz_ff        <= '0;
         wacc_ff      <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_QUERY_X: qx_ff <= csr_wdata;
               CSR_QUERY_Y: qy_ff <= csr_wdata;
               CSR_QUERY_Z: qz_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_ACCUM) begin
            if (!last_ff) begin
               wacc_ff <= wacc_in;
               cnt_ff  <= cnt_in;
               ovf_ff  <= ovf_in;
            end else if (out_free) begin
               wacc_ff <= '0;
               cnt_ff  <= '0;
               ovf_ff  <= 1'b0;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- datapath regs
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sum_ff <= wacc_in;
         rsp_cnt_ff <= cnt_in;
         rsp_ovf_ff <= ovf_in;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               for (int i = 0; i < 9; i++) begin
                  mag_ff[i] <= mag_new[i];
               end
               neg_ff  <= neg_new;
               last_ff <= req_if.last_triangle;
               step_ff <= '0;
            end
         end
         ST_NORM: begin
            if (mag_or64 == 64'd0) begin
               z_ff <= '0;
            end else if (mag_or64 >= 64'd524288) begin
               for (int i = 0; i < 9; i++) mag_ff[i] <= mag_ff[i] >> 4;
            end else if (mag_or64 >= 64'd32768) begin
               for (int i = 0; i < 9; i++) mag_ff[i] <= mag_ff[i] >> 1;
            end else if (mag_or64 < 64'd1024) begin
               for (int i = 0; i < 9; i++) mag_ff[i] <= mag_ff[i] << 4;
            end else if (mag_or64 < 64'd16384) begin
               for (int i = 0; i < 9; i++) mag_ff[i] <= mag_ff[i] << 1;
            end
         end
         ST_MUL: prod_ff <= prod_in;
         ST_ACC: begin
            acc_ff  <= acc_in;
            step_ff <= step_ff + 6'd1;
            case (op.dst)
               D_CR:    cr_ff[op.didx]  <= MA_W'(acc_in);
               D_DET:   det_ff          <= acc_in;
               D_SS:    ss_ff[op.didx]  <= SS_W'(acc_in);
               D_DOT:   dot_ff[op.didx] <= MA_W'(acc_in);
               D_P1:    p1_ff           <= P1_W'(acc_in);
               D_DIV:   div_ff          <= acc_in;
               default: ;
            endcase
            if (step_ff == MAC_STEP_SQRT) begin
               sq_sel_ff  <= 2'd0;
               sq_cnt_ff  <= '0;
               sq_src_ff  <= {ss_ff[0], (SQ_IN_W-SS_W)'(0)};
               sq_rem_ff  <= '0;
               sq_root_ff <= '0;
            end
         end
         ST_SQRT: begin
            if (sq_done) begin
               nrm_ff[sq_sel_ff] <= sq_root_in;
               sq_sel_ff  <= sq_sel_ff + 2'd1;
               sq_cnt_ff  <= '0;
               sq_src_ff  <= {sq_next_ss, (SQ_IN_W-SS_W)'(0)};
               sq_rem_ff  <= '0;
               sq_root_ff <= '0;
            end else begin
               sq_cnt_ff  <= sq_cnt_ff + 5'd1;
               sq_src_ff  <= sq_src_ff << 2;
               sq_rem_ff  <= sq_rem_in;
               sq_root_ff <= sq_root_in;
            end
         end
         ST_ATAN_PREP: begin
            cordic_ff <= '0;
            if (div_ff == '0 && det_ff == '0) begin
               z_ff <= '0;
            end else if (div_ff < 0) begin
               z_ff <= (det_ff >= 0) ? HALF_TURN : -HALF_TURN;
               x_ff <= -div_ff;
               y_ff <= -det_ff;
            end else begin
               z_ff <= '0;
               x_ff <= div_ff;
               y_ff <= det_ff;
            end
         end
         ST_ATAN_NORM: begin
            if (coarse_ok) begin
               x_ff <= x_ff <<< 4;
               y_ff <= y_ff <<< 4;
            end else if (fine_ok) begin
               x_ff <= x_ff <<< 1;
               y_ff <= y_ff <<< 1;
            end
         end
         ST_CORDIC: begin
            cordic_ff <= cordic_ff + 1'b1;
            if (y_ff >= 0) begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + tab;
            end else begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - tab;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- checks
   a_scaled_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && $past(state_ff) == ST_NORM) |->
      (mag_or64 < 64'd32768 && mag_or64 >= 64'd16384))
      else $error("vector scaling left the working range");

   a_cordic_x_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC) |-> !x_ff[ACC_W-1])
      else $error("cordic x went negative");

   a_rsp_from_accum: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ACCUM && last_ff))
      else $error("result raised outside the accumulate step");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(ovf_ff) |-> $past(reset) || $past(state_ff == ST_ACCUM && last_ff))
      else $error("overflow flag cleared before mesh end");

endmodule

>>> test/tmwn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmwn_checker
// Watches the triangle, result and register ports of the winding number
// block, keeps its own copy of the query point and the running sum, works out
// the expected result of every finished mesh and compares it field by field
// with what the block hands out.
// ----------------------------------------------------------------------------
module tmwn_checker
   import tmwn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tmwn_req_if         req_mon,
   tmwn_rsp_if         rsp_mon,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   output int          fail_count,
   output int          mesh_pending,
   output int          mesh_checked
);

   typedef struct {
      logic signed [31:0] sum;
      logic [19:0]        total;
      logic               ovf;
   } mesh_result_type;

   typedef longint coord9_type [9];

   localparam logic [31:0] ATAN_TURN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

   localparam int  STEPS    = 24;
   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -64'sd2147483648;
   localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

   longint          qx, qy, qz;
   longint          run_sum;
   logic [19:0]     run_count;
   logic            run_ovf;
   mesh_result_type expected_meshes[$];

   function automatic longint unsigned root64(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint abs_l(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // solid angle contribution of one triangle, Q8.24 turns
   function automatic longint triangle_turns(input coord9_type d);
      longint unsigned mag [9];
      longint unsigned m, na, nb, nc;
      bit     neg [9];
      longint v [9];
      longint det, ab, bc, ca, prod, dv, x, y, z, dx, dy, lim;
      m = 0;
      lim = longint'(1) << 49;
      for (int i = 0; i < 9; i++) begin
         neg[i] = d[i] < 0;
         mag[i] = neg[i] ? longint'(-d[i]) : longint'(d[i]);
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) return 0;
      while (m >= 64'd32768) begin
         for (int i = 0; i < 9; i++) mag[i] = mag[i] >> 1;
         m = m >> 1;
      end
      while (m < 64'd16384) begin
         for (int i = 0; i < 9; i++) mag[i] = mag[i] << 1;
         m = m << 1;
      end
      for (int i = 0; i < 9; i++) v[i] = neg[i] ? -longint'(mag[i]) : longint'(mag[i]);
      det = v[0] * (v[4] * v[8] - v[5] * v[7])
          + v[1] * (v[5] * v[6] - v[3] * v[8])
          + v[2] * (v[3] * v[7] - v[4] * v[6]);
      na = root64(longint'(v[0]*v[0] + v[1]*v[1] + v[2]*v[2]) << 12);
      nb = root64(longint'(v[3]*v[3] + v[4]*v[4] + v[5]*v[5]) << 12);
      nc = root64(longint'(v[6]*v[6] + v[7]*v[7] + v[8]*v[8]) << 12);
      ab = v[0]*v[3] + v[1]*v[4] + v[2]*v[5];
      bc = v[3]*v[6] + v[4]*v[7] + v[5]*v[8];
      ca = v[6]*v[0] + v[7]*v[1] + v[8]*v[2];
      prod = longint'((((na * nb) >> 6) * nc) >> 12);
      dv = prod + ((ab * longint'(nc)) >>> 6) + ((bc * longint'(na)) >>> 6)
         + ((ca * longint'(nb)) >>> 6);
      x = dv;
      y = det;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
         x = -x;
         y = -y;
      end
      while (abs_l(x) < lim && abs_l(y) < lim) begin
         x = x * 2;
         y = y * 2;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ATAN_TURN[i]);
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ATAN_TURN[i]);
         end
      end
      return (z + 128) >>> 8;
   endfunction

   assign mesh_pending = expected_meshes.size();

   always @(posedge clock) begin
      coord9_type      d;
      longint          s;
      mesh_result_type r, got;
      if (reset) begin
         qx = 0;
         qy = 0;
         qz = 0;
         run_sum = 0;
         run_count = 0;
         run_ovf = 0;
         fail_count <= 0;
         mesh_checked <= 0;
         expected_meshes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_QUERY_X: qx = longint'($signed(csr_wdata));
               CSR_QUERY_Y: qy = longint'($signed(csr_wdata));
               CSR_QUERY_Z: qz = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            d[0] = longint'(req_mon.vert_a_x) - qx;
            d[1] = longint'(req_mon.vert_a_y) - qy;
            d[2] = longint'(req_mon.vert_a_z) - qz;
            d[3] = longint'(req_mon.vert_b_x) - qx;
            d[4] = longint'(req_mon.vert_b_y) - qy;
            d[5] = longint'(req_mon.vert_b_z) - qz;
            d[6] = longint'(req_mon.vert_c_x) - qx;
            d[7] = longint'(req_mon.vert_c_y) - qy;
            d[8] = longint'(req_mon.vert_c_z) - qz;
            s = run_sum + triangle_turns(d);
            if (s > SUM_MAX) begin
               s = SUM_MAX;
               run_ovf = 1;
            end else if (s < SUM_MIN) begin
               s = SUM_MIN;
               run_ovf = 1;
            end
            run_sum = s;
            if (run_count != COUNT_MAX) run_count = run_count + 1;
            if (req_mon.last_triangle) begin
               r.sum = run_sum[31:0];
               r.total = run_count;
               r.ovf = run_ovf;
               expected_meshes.push_back(r);
               run_sum = 0;
               run_count = 0;
               run_ovf = 0;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            mesh_checked <= mesh_checked + 1;
            if (expected_meshes.size() == 0) begin
               $display("%0t unexpected result word: sum %0d total %0d ovf %0b", $time,
                        rsp_mon.winding_sum, rsp_mon.triangle_total, rsp_mon.sum_overflow);
               fail_count <= fail_count + 1;
            end else begin
               got = expected_meshes.pop_front();
               if (got.sum !== rsp_mon.winding_sum || got.total !== rsp_mon.triangle_total
                   || got.ovf !== rsp_mon.sum_overflow) begin
                  if (got.sum !== rsp_mon.winding_sum)
                     $display("%0t winding_sum mismatch: expected %0d actual %0d", $time,
                              got.sum, rsp_mon.winding_sum);
                  if (got.total !== rsp_mon.triangle_total)
                     $display("%0t triangle_total mismatch: expected %0d actual %0d", $time,
                              got.total, rsp_mon.triangle_total);
                  if (got.ovf !== rsp_mon.sum_overflow)
                     $display("%0t sum_overflow mismatch: expected %0b actual %0b", $time,
                              got.ovf, rsp_mon.sum_overflow);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> test/triangle_mesh_winding_number_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_mesh_winding_number_tb
// Feeds triangle meshes to the winding number block under several query
// points, with random stalls on both ports, a long output hold-off and a
// drain pause, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module triangle_mesh_winding_number_tb;
   import tmwn_pkg::*;

   typedef struct {
      logic signed [23:0] c [9];
      logic               last;
   } triangle_type;

   localparam logic [23:0] C_MAX = 24'h7FFFFF;
   localparam logic [23:0] C_MIN = 24'h800000;
   localparam logic [1:0]  CSR_UNUSED = 2'd3;
   localparam int ONE = 65536;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;
   int          fail_count, mesh_pending, mesh_checked;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_requests = 0;
   int          triangles_sent = 0;
   int          quiet_cycles = 0;
   logic signed [23:0] qpt [3];

   tmwn_req_if #(.COORD_BITS(24)) req ();
   tmwn_rsp_if #(.COUNT_BITS(20)) rsp ();

   triangle_mesh_winding_number uut (
      .clock(clock), .reset(reset), .req_if(req), .rsp_if(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   tmwn_checker chk (
      .clock(clock), .reset(reset), .req_mon(req), .rsp_mon(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .mesh_pending(mesh_pending),
      .mesh_checked(mesh_checked));

   always #5 clock = ~clock;

   initial begin
      req.valid = 0;
      req.last_triangle = 0;
      req.vert_a_x = 0; req.vert_a_y = 0; req.vert_a_z = 0;
      req.vert_b_x = 0; req.vert_b_y = 0; req.vert_b_z = 0;
      req.vert_c_x = 0; req.vert_c_y = 0; req.vert_c_z = 0;
      rsp.ready = 0;
   end

   // receiver: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      int hold_seen;
      int hold_left;
      if (reset) begin
         rsp.ready <= 0;
         hold_seen = 0;
         hold_left = 0;
      end else begin
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no traffic, %0d results outstanding", $time, mesh_pending);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_tri(input triangle_type t);
      req.valid <= 1;
      req.vert_a_x <= t.c[0]; req.vert_a_y <= t.c[1]; req.vert_a_z <= t.c[2];
      req.vert_b_x <= t.c[3]; req.vert_b_y <= t.c[4]; req.vert_b_z <= t.c[5];
      req.vert_c_x <= t.c[6]; req.vert_c_y <= t.c[7]; req.vert_c_z <= t.c[8];
      req.last_triangle <= t.last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      triangles_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain();
      if (req.valid) begin
         req.valid <= 0;
         @(posedge clock);
      end
      while (mesh_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_query(input logic [23:0] x, input logic [23:0] y,
                              input logic [23:0] z);
      drain();
      csr_we <= 1;
      csr_index <= CSR_QUERY_X; csr_wdata <= x;
      @(posedge clock);
      csr_index <= CSR_QUERY_Y; csr_wdata <= y;
      @(posedge clock);
      csr_index <= CSR_QUERY_Z; csr_wdata <= z;
      @(posedge clock);
      // unused index, must be ignored
      csr_index <= CSR_UNUSED; csr_wdata <= 24'($urandom);
      @(posedge clock);
      csr_we <= 0;
      qpt[0] = x; qpt[1] = y; qpt[2] = z;
      @(posedge clock);
   endtask

   function automatic logic [23:0] rnd_coord();
      case ($urandom_range(9))
         0: return C_MAX;
         1: return C_MIN;
         2: return 24'd0;
         3, 4, 5: return 24'($signed($urandom_range(8 * ONE)) - 4 * ONE);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] near_q(input int axis, input int spread);
      return 24'(qpt[axis] + $signed($urandom_range(2 * spread)) - spread);
   endfunction

   task automatic send_flat(input int ox, input int oy, input int oz, input logic last);
      triangle_type t;
      t.c = '{24'(ox + ONE), 24'(oy), 24'(oz + 64),
              24'(ox - ONE / 2), 24'(oy + 56756), 24'(oz + 64),
              24'(ox - ONE / 2), 24'(oy - 56756), 24'(oz + 64)};
      t.last = last;
      send_tri(t);
   endtask

   task automatic send_random_mesh();
      triangle_type t;
      int n;
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < 9; i++)
            t.c[i] = ($urandom_range(1)) ? rnd_coord() : near_q(i % 3, $urandom_range(1, ONE));
         t.last = (k == n - 1);
         send_tri(t);
      end
   endtask

   // closed tetrahedron, consistently oriented, around or beside the query
   task automatic send_tetra();
      logic signed [23:0] p [4][3];
      int fc [4][3];
      int spread;
      triangle_type t;
      fc = '{'{0, 1, 2}, '{0, 3, 1}, '{0, 2, 3}, '{1, 3, 2}};
      spread = $urandom_range(1, 4) * ONE;
      for (int v = 0; v < 4; v++)
         for (int a = 0; a < 3; a++) p[v][a] = near_q(a, spread);
      for (int f = 0; f < 4; f++) begin
         for (int v = 0; v < 3; v++)
            for (int a = 0; a < 3; a++) t.c[v * 3 + a] = p[fc[f][v]][a];
         t.last = (f == 3);
         send_tri(t);
      end
   endtask

   task automatic random_phase(input int word_count, input int pause_at);
      int start;
      start = triangles_sent;
      while (triangles_sent - start < word_count) begin
         if (pause_at > 0 && triangles_sent - start >= pause_at) begin
            pause_at = 0;
            drain();
         end
         if ($urandom_range(1)) send_tetra();
         else send_random_mesh();
      end
   endtask

   initial begin
      triangle_type t;
      qpt = '{24'd0, 24'd0, 24'd0};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed, query at origin after reset
      send_idle_pct = 14;
      recv_idle_pct = 51;
      t.c = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
      t.last = 1;
      send_tri(t);
      t.c = '{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX};
      send_tri(t);
      t.c = '{C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX};
      send_tri(t);
      // collinear vectors, zero solid angle
      t.c = '{24'(ONE), 24'd0, 24'd0, 24'(2 * ONE), 24'd0, 24'd0,
              24'(-ONE), 24'd0, 24'd0};
      send_tri(t);
      // one vertex on the query point
      t.c = '{24'd0, 24'd0, 24'd0, 24'(ONE), 24'd0, 24'd0, 24'd0, 24'(ONE), 24'd0};
      send_tri(t);
      t.c = '{24'(ONE), 24'd0, 24'd0, 24'd0, 24'(ONE), 24'd0, 24'd0, 24'd0, 24'(ONE)};
      send_tri(t);
      t.c = '{24'(ONE), 24'd0, 24'd0, 24'd0, 24'd0, 24'(ONE), 24'd0, 24'(ONE), 24'd0};
      send_tri(t);
      // tiny vectors, scaled up
      t.c = '{24'd1, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd1};
      send_tri(t);
      t.c = '{24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
      send_tri(t);
      // accumulator saturation, both signs
      for (int k = 0; k < 300; k++) send_flat(0, 0, 0, k == 299);
      for (int k = 0; k < 300; k++) send_flat(0, 0, -128, k == 299);
      random_phase(40, 0);

      write_query(C_MAX, C_MAX, C_MAX);
      random_phase(40, 0);

      send_idle_pct = 51;
      recv_idle_pct = 14;
      write_query(C_MIN, C_MIN, C_MIN);
      hold_requests++;
      random_phase(40, 0);

      write_query(24'($urandom), 24'($urandom), 24'($urandom));
      random_phase(40, 20);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_query(24'($urandom_range(2 * ONE)), 24'($urandom_range(2 * ONE)),
                  24'($urandom_range(2 * ONE)));
      random_phase(40, 0);
      write_query(24'd0, C_MAX, C_MIN);
      random_phase(40, 0);

      drain();
      $display("covered %0d triangles in %0d meshes over six query points,", triangles_sent,
               mesh_checked);
      $display("with saturation both ways, closed tetrahedra, port stalls and hold-off");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
